FILE: hw/rtl/calendar_clock_counter_assert.svh
// Assertion macros for the calendar clock counter monitor.
// All checks sample on the rising edge of clk_i and are muted in reset.
`ifndef CALENDAR_CLOCK_COUNTER_ASSERT_SVH
`define CALENDAR_CLOCK_COUNTER_ASSERT_SVH

// Same-cycle implication.
`define CALCLK_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CALCLK_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/calclk_pkg.sv
// ----------------------------------------------------------------------------
// calclk_pkg
// Shared types, constants and the month length function of the calendar clock.
// ----------------------------------------------------------------------------
package calclk_pkg;

  // Full calendar time
  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  dow;
    logic [15:0] week;
  } cal_time_t;

  // Function codes
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_LOAD = 1'b1;

  // Reset values
  localparam logic [5:0] RESET_STEP = 6'd10;
  localparam cal_time_t RESET_TIME = '{
    year:   16'd2022,
    month:  4'd1,
    day:    5'd1,
    hour:   5'd0,
    minute: 6'd0,
    second: 6'd0,
    dow:    3'd1,
    week:   16'd1
  };

  // Wrap limits
  localparam logic [6:0] SEC_PER_MIN   = 7'd60;
  localparam logic [6:0] MIN_PER_HOUR  = 7'd60;
  localparam logic [5:0] HOUR_PER_DAY  = 6'd24;
  localparam logic [4:0] MONTH_WRAP    = 5'd13;
  localparam logic [2:0] DAYS_PER_WEEK = 3'd7;
  localparam logic [3:0] MONTH_MAX     = 4'd12;
  localparam logic [4:0] HOUR_MAX      = 5'd23;
  localparam logic [5:0] MINSEC_MAX    = 6'd59;

  // Days in a month; leap year when the year is a multiple of four
  function automatic logic [4:0] month_len(input logic [1:0] year_lsb,
                                           input logic [3:0] month);
    logic [4:0] len;
    case (month) inside
      4'd2:                     len = (year_lsb == 2'd0) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
      default:                  len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

FILE: hw/rtl/calendar_clock_counter.sv
// ----------------------------------------------------------------------------
// calendar_clock_counter: calendar clock with tick and load transactions
// The input register feeds the time register that drives the outputs.
// One item per cycle unless the output stalls; carry ripple is combinational.
// Async active-low reset: time 2022-01-01 00:00:00, weekday 1, week 1, step 10.
// ----------------------------------------------------------------------------
module calendar_clock_counter (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [15:0] load_year_i,
  input  logic [3:0]  load_month_i,
  input  logic [4:0]  load_day_i,
  input  logic [4:0]  load_hour_i,
  input  logic [5:0]  load_minute_i,
  input  logic [5:0]  load_second_i,
  input  logic [2:0]  load_day_of_week_i,
  input  logic [15:0] load_week_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] cur_year_o,
  output logic [3:0]  cur_month_o,
  output logic [4:0]  cur_day_o,
  output logic [4:0]  cur_hour_o,
  output logic [5:0]  cur_minute_o,
  output logic [5:0]  cur_second_o,
  output logic [2:0]  cur_day_of_week_o,
  output logic [15:0] cur_week_o,
  output logic        load_rejected_o
);

  logic                  s1_valid_q;
  logic                  s1_func_q;
  calclk_pkg::cal_time_t s1_load_q;
  logic [5:0]            step_q;
  calclk_pkg::cal_time_t time_q, time_d;
  logic                  rej_q, rej_d;
  logic                  out_valid_q;
  logic                  out_free;
  logic                  s1_fire;
  logic                  in_fire;

  // Handshake: the time register is the result register, so it only moves
  // when the output side can take a new transaction.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_fire    = in_valid_i && !in_stall_o;

  // Control and time state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      step_q      <= calclk_pkg::RESET_STEP;
      time_q      <= calclk_pkg::RESET_TIME;
      rej_q       <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
        time_q      <= time_d;
        rej_q       <= rej_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        step_q <= cfg_wdata_i;
      end
    end
  end

  // Input payload register
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_func_q        <= func_i;
      s1_load_q.year   <= load_year_i;
      s1_load_q.month  <= load_month_i;
      s1_load_q.day    <= load_day_i;
      s1_load_q.hour   <= load_hour_i;
      s1_load_q.minute <= load_minute_i;
      s1_load_q.second <= load_second_i;
      s1_load_q.dow    <= load_day_of_week_i;
      s1_load_q.week   <= load_week_i;
    end
  end

  // Next time
  calclk_next u_next (
    .cur_i      (time_q),
    .func_i     (s1_func_q),
    .load_i     (s1_load_q),
    .step_i     (step_q),
    .nxt_o      (time_d),
    .rejected_o (rej_d)
  );

  // Outputs
  assign out_valid_o       = out_valid_q;
  assign cur_year_o        = time_q.year;
  assign cur_month_o       = time_q.month;
  assign cur_day_o         = time_q.day;
  assign cur_hour_o        = time_q.hour;
  assign cur_minute_o      = time_q.minute;
  assign cur_second_o      = time_q.second;
  assign cur_day_of_week_o = time_q.dow;
  assign cur_week_o        = time_q.week;
  assign load_rejected_o   = rej_q;

endmodule

FILE: hw/rtl/calclk_next.sv
// ----------------------------------------------------------------------------
// calclk_next
// Next calendar time for one transaction: tick with carry ripple, or a
// range-checked load.
// ----------------------------------------------------------------------------
module calclk_next (
  input  calclk_pkg::cal_time_t cur_i,
  input  logic                  func_i,
  input  calclk_pkg::cal_time_t load_i,
  input  logic [5:0]            step_i,
  output calclk_pkg::cal_time_t nxt_o,
  output logic                  rejected_o
);

  logic [6:0]            sec_sum;
  logic [6:0]            min_inc;
  logic [5:0]            hour_inc;
  logic [5:0]            day_inc;
  logic [4:0]            mon_inc;
  logic [4:0]            day_lim;
  logic [4:0]            load_lim;
  logic                  load_ok;
  calclk_pkg::cal_time_t tick_t;

  assign sec_sum  = {1'b0, cur_i.second} + {1'b0, step_i};
  assign min_inc  = {1'b0, cur_i.minute} + 7'd1;
  assign hour_inc = {1'b0, cur_i.hour} + 6'd1;
  assign day_inc  = {1'b0, cur_i.day} + 6'd1;
  assign mon_inc  = {1'b0, cur_i.month} + 5'd1;
  assign day_lim  = calclk_pkg::month_len(cur_i.year[1:0], cur_i.month);
  assign load_lim = calclk_pkg::month_len(load_i.year[1:0], load_i.month);

  // Tick: seconds, then one carry rippling up to the year
  always_comb begin
    tick_t = cur_i;
    if (sec_sum >= calclk_pkg::SEC_PER_MIN) begin
      tick_t.second = '0;
      if (min_inc >= calclk_pkg::MIN_PER_HOUR) begin
        tick_t.minute = '0;
        if (hour_inc >= calclk_pkg::HOUR_PER_DAY) begin
          tick_t.hour = '0;
          // day and month
          if (day_inc > {1'b0, day_lim}) begin
            tick_t.day = 5'd1;
            if (mon_inc >= calclk_pkg::MONTH_WRAP) begin
              tick_t.month = 4'd1;
              tick_t.year  = cur_i.year + 16'd1;
            end else begin
              tick_t.month = mon_inc[3:0];
            end
          end else begin
            tick_t.day = day_inc[4:0];
          end
          // day of week and week count
          if (cur_i.dow >= calclk_pkg::DAYS_PER_WEEK) begin
            tick_t.dow  = 3'd1;
            tick_t.week = cur_i.week + 16'd1;
          end else begin
            tick_t.dow = cur_i.dow + 3'd1;
          end
        end else begin
          tick_t.hour = hour_inc[4:0];
        end
      end else begin
        tick_t.minute = min_inc[5:0];
      end
    end else begin
      tick_t.second = sec_sum[5:0];
    end
  end

  // Load range check
  assign load_ok = (load_i.month != 4'd0) && (load_i.month <= calclk_pkg::MONTH_MAX)
                && (load_i.day != 5'd0) && (load_i.day <= load_lim)
                && (load_i.hour <= calclk_pkg::HOUR_MAX)
                && (load_i.minute <= calclk_pkg::MINSEC_MAX)
                && (load_i.second <= calclk_pkg::MINSEC_MAX)
                && (load_i.dow != 3'd0);

  // Select the result
  always_comb begin
    nxt_o      = tick_t;
    rejected_o = 1'b0;
    if (func_i == calclk_pkg::FUNC_LOAD) begin
      nxt_o      = load_ok ? load_i : cur_i;
      rejected_o = !load_ok;
    end
  end

endmodule

FILE: hw/rtl/calclk_monitor.sv
// ----------------------------------------------------------------------------
// calclk_monitor
// Port-level checks on the calendar clock counter, bound to the top level.
// ----------------------------------------------------------------------------
`include "calendar_clock_counter_assert.svh"

module calclk_monitor (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] cur_year_o,
  input logic [3:0]  cur_month_o,
  input logic [4:0]  cur_day_o,
  input logic [4:0]  cur_hour_o,
  input logic [5:0]  cur_minute_o,
  input logic [5:0]  cur_second_o,
  input logic [2:0]  cur_day_of_week_o,
  input logic [15:0] cur_week_o,
  input logic        load_rejected_o
);

  logic [61:0] out_bus;
  logic        fields_ok;

  assign out_bus = {cur_year_o, cur_month_o, cur_day_o, cur_hour_o, cur_minute_o,
                    cur_second_o, cur_day_of_week_o, cur_week_o, load_rejected_o};

  // Each field of a shown time is in range; the day is only checked nonzero
  assign fields_ok = (cur_month_o != 4'd0) && (cur_month_o <= 4'd12)
                  && (cur_day_o != 5'd0) && (cur_hour_o <= 5'd23)
                  && (cur_minute_o <= 6'd59) && (cur_second_o <= 6'd59)
                  && (cur_day_of_week_o != 3'd0);

  // A stalled result holds its value
  `CALCLK_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_bus), "stalled result changed")

  // Result fields stay in range
  `CALCLK_ASSERT_NOW(a_out_range, out_valid_o, fields_ok, "result field out of range")

  // An empty output side never back-pressures the input
  `CALCLK_ASSERT_NOW(a_no_stall_empty, !out_valid_o, !in_stall_o, "input stalled with output empty")

  // Input stall only while the output is stalled
  `CALCLK_ASSERT_NOW(a_stall_cause, in_stall_o, out_valid_o && out_stall_i, "input stall without output stall")

endmodule

bind calendar_clock_counter calclk_monitor u_calclk_monitor (.*);

FILE: tb/calendar_clock_counter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// calendar_clock_counter_tb: self-checking bench for the calendar clock
// Drives tick and load transactions with random gaps on both channels. A
// scoreboard keeps its own calendar and predicts the time that each
// transaction leaves behind. Each returned reading is compared field by field.
// The second step is rewritten between phases, from zero up to the 6-bit max.
// ----------------------------------------------------------------------------
module calendar_clock_counter_tb;

  localparam int RAND_PER_PHASE = 213;
  localparam int NUM_PHASES     = 6;
  localparam int LONG_HOLD      = 80;
  localparam int SETTLE_CYCLES  = 4;

  // One input transaction: function code plus the time fields of a load
  typedef struct packed {
    logic                  func;
    calclk_pkg::cal_time_t load;
  } clk_request_t;

  // One output transaction: time after the item plus the reject flag
  typedef struct packed {
    calclk_pkg::cal_time_t now;
    logic                  rejected;
  } clk_reading_t;

  // --------------------------------------------------------------------------
  // Scoreboard: private calendar state and the queue of predicted readings
  // --------------------------------------------------------------------------
  class calendar_ledger;
    calclk_pkg::cal_time_t now;
    logic [5:0]            step;
    clk_reading_t          expected_readings[$];
    int                    mismatches;

    function new();
      now        = calclk_pkg::RESET_TIME;
      step       = calclk_pkg::RESET_STEP;
      mismatches = 0;
    endfunction

    static function int month_days(logic [15:0] year, logic [3:0] month);
      case (month)
        4'd2:                    return (year[1:0] == 2'd0) ? 29 : 28;
        4'd4, 4'd6, 4'd9, 4'd11: return 30;
        default:                 return 31;
      endcase
    endfunction

    function void set_step(logic [5:0] value);
      step = value;
    endfunction

    function int outstanding();
      return expected_readings.size();
    endfunction

    // Day rollover: month and year carry, weekday and week count
    function void advance_day();
      int next;
      next = int'(now.day) + 1;
      if (next > month_days(now.year, now.month)) begin
        now.day = 5'd1;
        next    = int'(now.month) + 1;
        if (next >= 13) begin
          now.month = 4'd1;
          now.year  = now.year + 16'd1;
        end else begin
          now.month = 4'(next);
        end
      end else begin
        now.day = 5'(next);
      end
      if (now.dow >= 3'd7) begin
        now.dow  = 3'd1;
        now.week = now.week + 16'd1;
      end else begin
        now.dow = now.dow + 3'd1;
      end
    endfunction

    // Tick: add the step; any overflow clears seconds and carries one minute
    function void advance_clock();
      int next;
      next = int'(now.second) + int'(step);
      if (next < 60) begin
        now.second = 6'(next);
        return;
      end
      now.second = 6'd0;
      next = int'(now.minute) + 1;
      if (next < 60) begin
        now.minute = 6'(next);
        return;
      end
      now.minute = 6'd0;
      next = int'(now.hour) + 1;
      if (next < 24) begin
        now.hour = 5'(next);
        return;
      end
      now.hour = 5'd0;
      advance_day();
    endfunction

    function bit load_in_range(calclk_pkg::cal_time_t t);
      return t.month >= 4'd1 && t.month <= 4'd12 &&
             t.day >= 5'd1 && int'(t.day) <= month_days(t.year, t.month) &&
             t.hour <= 5'd23 && t.minute <= 6'd59 && t.second <= 6'd59 &&
             t.dow >= 3'd1 && t.dow <= 3'd7;
    endfunction

    // Accepted input: update the calendar and queue the reading it implies
    function void note_request(clk_request_t r);
      clk_reading_t pred;
      pred.rejected = 1'b0;
      if (r.func == calclk_pkg::FUNC_TICK) begin
        advance_clock();
      end else if (load_in_range(r.load)) begin
        now = r.load;
      end else begin
        pred.rejected = 1'b1;
      end
      pred.now = now;
      expected_readings.push_back(pred);
    endfunction

    task report(string msg);
      mismatches++;
      $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task check_field(string name, int got, int want);
      if (got != want)
        report($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // Accepted output: compare against the oldest prediction
    task check_reading(clk_reading_t got);
      clk_reading_t want;
      if (expected_readings.size() == 0) begin
        report("reading arrived with no transaction pending");
        return;
      end
      want = expected_readings.pop_front();
      check_field("cur_year",        got.now.year,   want.now.year);
      check_field("cur_month",       got.now.month,  want.now.month);
      check_field("cur_day",         got.now.day,    want.now.day);
      check_field("cur_hour",        got.now.hour,   want.now.hour);
      check_field("cur_minute",      got.now.minute, want.now.minute);
      check_field("cur_second",      got.now.second, want.now.second);
      check_field("cur_day_of_week", got.now.dow,    want.now.dow);
      check_field("cur_week",        got.now.week,   want.now.week);
      check_field("load_rejected",   got.rejected,   want.rejected);
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Signals and DUT
  // --------------------------------------------------------------------------
  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [5:0]  cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        func_i;
  logic [15:0] load_year_i;
  logic [3:0]  load_month_i;
  logic [4:0]  load_day_i;
  logic [4:0]  load_hour_i;
  logic [5:0]  load_minute_i;
  logic [5:0]  load_second_i;
  logic [2:0]  load_day_of_week_i;
  logic [15:0] load_week_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [15:0] cur_year_o;
  logic [3:0]  cur_month_o;
  logic [4:0]  cur_day_o;
  logic [4:0]  cur_hour_o;
  logic [5:0]  cur_minute_o;
  logic [5:0]  cur_second_o;
  logic [2:0]  cur_day_of_week_o;
  logic [15:0] cur_week_o;
  logic        load_rejected_o;

  calendar_ledger ledger = new();
  bit             source_quiet;
  bit             sink_quiet;
  bit             long_hold_req;

  calendar_clock_counter uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .func_i             (func_i),
    .load_year_i        (load_year_i),
    .load_month_i       (load_month_i),
    .load_day_i         (load_day_i),
    .load_hour_i        (load_hour_i),
    .load_minute_i      (load_minute_i),
    .load_second_i      (load_second_i),
    .load_day_of_week_i (load_day_of_week_i),
    .load_week_i        (load_week_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .cur_year_o         (cur_year_o),
    .cur_month_o        (cur_month_o),
    .cur_day_o          (cur_day_o),
    .cur_hour_o         (cur_hour_o),
    .cur_minute_o       (cur_minute_o),
    .cur_second_o       (cur_second_o),
    .cur_day_of_week_o  (cur_day_of_week_o),
    .cur_week_o         (cur_week_o),
    .load_rejected_o    (load_rejected_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #3_000_000;
    $display("calendar_clock_counter_tb: errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  // Offer one transaction after a random gap; valid stays high on return
  task automatic send_request(clk_request_t r);
    int gap;
    gap = source_quiet ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    func_i             <= r.func;
    load_year_i        <= r.load.year;
    load_month_i       <= r.load.month;
    load_day_i         <= r.load.day;
    load_hour_i        <= r.load.hour;
    load_minute_i      <= r.load.minute;
    load_second_i      <= r.load.second;
    load_day_of_week_i <= r.load.dow;
    load_week_i        <= r.load.week;
    do @(posedge clk_i); while (in_stall_o);
    ledger.note_request(r);
  endtask

  function automatic calclk_pkg::cal_time_t random_fields();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[60:0];
  endfunction

  // Tick; the load fields carry junk that the block must ignore
  task automatic send_tick();
    clk_request_t r;
    r.func = calclk_pkg::FUNC_TICK;
    r.load = random_fields();
    send_request(r);
  endtask

  task automatic send_load(int y, int mo, int d, int h, int mi, int s, int dw, int wk);
    clk_request_t r;
    r.func = calclk_pkg::FUNC_LOAD;
    r.load = '{year: 16'(y), month: 4'(mo), day: 5'(d), hour: 5'(h),
               minute: 6'(mi), second: 6'(s), dow: 3'(dw), week: 16'(wk)};
    send_request(r);
  endtask

  // Mostly ticks; loads lean toward end-of-day/month/year so carries fire
  function automatic clk_request_t random_request();
    clk_request_t r;
    int           pick;
    int           len;
    r.load = random_fields();
    pick   = $urandom_range(0, 99);
    if (pick < 60) begin
      r.func = calclk_pkg::FUNC_TICK;
    end else begin
      r.func = calclk_pkg::FUNC_LOAD;
      if (pick < 88) begin
        r.load.year  = ($urandom_range(0, 3) == 0) ? 16'(65535 - $urandom_range(0, 3))
                                                    : 16'($urandom);
        r.load.month = 4'($urandom_range(1, 12));
        len = calendar_ledger::month_days(r.load.year, r.load.month);
        r.load.day    = $urandom_range(0, 1) ? 5'(len - $urandom_range(0, 1))
                                             : 5'($urandom_range(1, len));
        r.load.hour   = $urandom_range(0, 1) ? 5'd23 : 5'($urandom_range(0, 23));
        r.load.minute = $urandom_range(0, 1) ? 6'd59 : 6'($urandom_range(0, 59));
        r.load.second = $urandom_range(0, 1) ? 6'($urandom_range(45, 59))
                                             : 6'($urandom_range(0, 59));
        r.load.dow    = 3'($urandom_range(1, 7));
        if ($urandom_range(0, 3) == 0) r.load.week = 16'hFFFF;
        // occasional day one past the end of the month
        if ($urandom_range(0, 9) == 0) r.load.day = 5'(len + 1);
      end
    end
    return r;
  endfunction

  // Stop offering and wait out every pending reading plus pipeline settle
  task automatic finish_outstanding();
    in_valid_i <= 1'b0;
    while (ledger.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_step(logic [5:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    ledger.set_step(value);
  endtask

  // --------------------------------------------------------------------------
  // Output side: random stalls, one long hold on request
  // --------------------------------------------------------------------------
  initial begin
    int gap;
    int taken;
    clk_reading_t got;
    taken = 0;
    out_stall_i <= 1'b1;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (taken % 40 == 0) sink_quiet = ($urandom_range(0, 3) == 0);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else begin
        gap = sink_quiet ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
          out_stall_i <= 1'b1;
          repeat (gap) @(posedge clk_i);
        end
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      got.now.year   = cur_year_o;
      got.now.month  = cur_month_o;
      got.now.day    = cur_day_o;
      got.now.hour   = cur_hour_o;
      got.now.minute = cur_minute_o;
      got.now.second = cur_second_o;
      got.now.dow    = cur_day_of_week_o;
      got.now.week   = cur_week_o;
      got.rejected   = load_rejected_o;
      ledger.check_reading(got);
      taken++;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [5:0] step_plan [NUM_PHASES];
    step_plan = '{6'd10, 6'd0, 6'd63, 6'd1, 6'd59, 6'd0};
    step_plan[NUM_PHASES-1] = 6'($urandom_range(2, 58));

    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_wdata_i        <= 6'd0;
    in_valid_i         <= 1'b0;
    func_i             <= calclk_pkg::FUNC_TICK;
    load_year_i        <= 16'd0;
    load_month_i       <= 4'd0;
    load_day_i         <= 5'd0;
    load_hour_i        <= 5'd0;
    load_minute_i      <= 6'd0;
    load_second_i      <= 6'd0;
    load_day_of_week_i <= 3'd0;
    load_week_i        <= 16'd0;
    source_quiet = 1'b0;
    long_hold_req = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset step, calendar edges, every kind of bad load
    send_tick();
    send_load(65535, 12, 31, 23, 59, 59, 7, 65535);  // year and week both wrap
    send_tick();
    send_load(2023, 2, 28, 23, 59, 55, 3, 10);       // non-leap February end
    send_tick();
    send_load(2024, 2, 28, 23, 59, 50, 4, 20);       // leap day follows
    send_tick();
    send_load(2024, 2, 29, 23, 59, 59, 5, 21);
    send_tick();
    send_load(2024, 4, 30, 23, 59, 55, 6, 30);       // 30-day month rolls the day
    send_tick();
    send_load(2023, 2, 29, 0, 0, 0, 1, 0);           // Feb 29 outside leap year
    send_load(2024, 0, 1, 0, 0, 0, 1, 0);            // month zero
    send_load(2024, 15, 1, 0, 0, 0, 1, 0);           // month too large
    send_load(2024, 5, 0, 0, 0, 0, 1, 0);            // day zero
    send_load(2024, 4, 31, 0, 0, 0, 1, 0);           // day 31 in April
    send_load(2024, 5, 1, 31, 0, 0, 1, 0);           // hour too large
    send_load(2024, 5, 1, 24, 0, 0, 1, 0);
    send_load(2024, 5, 1, 0, 63, 0, 1, 0);           // minute too large
    send_load(2024, 5, 1, 0, 0, 63, 1, 0);           // second too large
    send_load(2024, 5, 1, 0, 0, 0, 0, 0);            // weekday zero
    send_load(65535, 15, 31, 31, 63, 63, 7, 65535);  // every bit set
    send_load(0, 0, 0, 0, 0, 0, 0, 0);               // every bit clear
    send_tick();

    // Random phases, one second step each
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase > 0) begin
        finish_outstanding();
        write_step(step_plan[phase]);
      end
      for (int i = 0; i < RAND_PER_PHASE; i++) begin
        if (i % 50 == 0) source_quiet = ($urandom_range(0, 3) == 0);
        // back up the output so the block stalls its input
        if (phase == 2 && i == 100) begin
          long_hold_req = 1'b1;
          source_quiet  = 1'b1;
        end
        send_request(random_request());
      end
    end
    finish_outstanding();

    if (ledger.mismatches == 0) begin
      $display("calendar_clock_counter_tb: clean");
    end else begin
      $display("calendar_clock_counter_tb: errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/calclk_pkg.sv
hw/rtl/calclk_next.sv
hw/rtl/calendar_clock_counter.sv
hw/rtl/calclk_monitor.sv
tb/calendar_clock_counter_tb.sv
